// ----- rtl/core/ffa_pkg.sv -----
// Shared types and constants for the first-fit free-list allocator.
// Used by the allocator top level and its checker.
`default_nettype none

package ffa_pkg;

  // Region table geometry
  localparam int TableDepth = 64;
  localparam int AddrWidth  = 32;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);

  // Addresses wrap at AddrWidth bits
  localparam logic [31:0] AddrMask = 32'((64'd1 << AddrWidth) - 64'd1);

  // Request kinds carried on the input tuser
  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusNoFit = 2'd1,
    StatusLost  = 2'd2
  } status_e;

  // One free region as stored in the table RAM
  typedef struct packed {
    logic [31:0] len;
    logic [31:0] start;
  } entry_t;

  // Result word, last field in the lowest bits
  typedef struct packed {
    logic [32:0]     free_total;
    logic [31:0]     lost_bytes;
    logic [31:0]     lost_frees;
    logic [CntW-1:0] high_water;
    logic [CntW-1:0] entry_count;
    status_e         status;
    logic [31:0]     alloc_addr;
  } result_t;

  localparam int InW     = 64;
  localparam int OutRawW = $bits(result_t);
  localparam int OutW    = ((OutRawW + 7) / 8) * 8;

endpackage

`default_nettype wire

// ----- rtl/core/ffa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ffa_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/first_fit_free_list_allocator.sv -----
// First-fit free-list allocator top level: sequencer, counters, output register.
// Depends on ffa_pkg and ffa_ram (the address-ordered region table).
`default_nettype none

// The allocator keeps up to 64 free regions (start, length) ordered by start
// address in a single RAM with one write and one registered read port. An
// allocate word takes the first region long enough; a free word merges with
// its neighbors or is inserted, else it is counted as lost (table full).
// Each request gives one result word with the address, a status and the
// running statistics. A request is taken only while the sequencer is idle.
// From acceptance the sequencer first scans one table entry per cycle up to
// the first fitting region or the insertion slot (at most the entry count).
// Removing or inserting a region then moves the entries behind it by one
// place (one per cycle through the RAM port pair), or writes in place when
// no entry moves. Scan and moves together touch at most 64 entries.
// A finished result sits in an output register, and the next request is
// accepted while it waits to be taken.
module first_fit_free_list_allocator import ffa_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [InW-1:0]  s_axis_tdata,   // addr[31:0], size[63:32]
  input  wire logic            s_axis_tuser,   // cmd
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic      [OutW-1:0] m_axis_tdata    // alloc_addr[31:0], status[33:32],
                                               // entry_count[40:34], high_water[47:41],
                                               // lost_frees[79:48], lost_bytes[111:80],
                                               // free_total[144:112], zero pad
);

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDecide,
    StMerge,
    StShiftDn,
    StShiftUp,
    StPut,
    StDone
  } state_e;

  state_e          state_q;
  logic            cmd_q;
  logic [31:0]     addr_q, size_q, tail_q, acc_q, res_addr_q;
  status_e         res_status_q;
  logic [CntW-1:0] count_q, peak_q, rd_idx_q, pos_q;
  logic [31:0]     lost_n_q, lost_b_q;
  logic [32:0]     sum_q;
  logic            rv_q, has_prev_q, has_cur_q, more_q;
  logic [IdxW-1:0] rv_idx_q;
  entry_t          prev_q, cur_q;
  logic            m_valid_q;
  logic [OutW-1:0] m_data_q;

  // RAM ports
  logic            ram_we, rd_issue;
  logic [IdxW-1:0] ram_waddr;
  entry_t          ram_wdata, rd_entry;
  logic [$bits(entry_t)-1:0] ram_rdata;

  // decision terms
  logic            prev_match, next_match, fits, last_rd, scan_stop;
  logic [31:0]     prev_end;
  logic [CntW-1:0] cnt_inc;
  result_t         res;

  ffa_ram #(
    .Width ($bits(entry_t)),
    .Depth (TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_issue),
    .raddr_i (rd_idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // compare terms on the returned entry and on the captured neighbors
  always_comb begin
    prev_end   = (prev_q.start + prev_q.len) & AddrMask;
    prev_match = has_prev_q && (prev_end == addr_q);
    next_match = has_cur_q && (tail_q == cur_q.start);
    fits       = rd_entry.len >= size_q;
    last_rd    = CntW'(rv_idx_q) == (count_q - CntW'(1));
    cnt_inc    = count_q + CntW'(1);
    // scan ends on an empty table, a hit or the last entry
    scan_stop  = (count_q == '0) ||
                 (rv_q && (last_rd || ((cmd_q == CmdAlloc) ? fits
                                                           : (rd_entry.start > addr_q))));
  end

  // read issue per state
  always_comb begin
    unique case (state_q)
      StScan:    rd_issue = rd_idx_q < count_q;
      StShiftDn: rd_issue = rd_idx_q <= count_q;
      StShiftUp: rd_issue = more_q;
      default:   rd_issue = 1'b0;
    endcase
  end

  // table writes per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    unique case (state_q)
      StDecide: begin
        if (cmd_q == CmdAlloc) begin
          if (has_cur_q && (cur_q.len != size_q)) begin
            ram_we          = 1'b1;
            ram_waddr       = pos_q[IdxW-1:0];
            ram_wdata.start = (cur_q.start + size_q) & AddrMask;
            ram_wdata.len   = cur_q.len - size_q;
          end
        end else if (prev_match && !next_match) begin
          ram_we          = 1'b1;
          ram_waddr       = IdxW'(pos_q - CntW'(1));
          ram_wdata.start = prev_q.start;
          ram_wdata.len   = prev_q.len + size_q;
        end else if (!prev_match && next_match) begin
          ram_we          = 1'b1;
          ram_waddr       = pos_q[IdxW-1:0];
          ram_wdata.start = addr_q;
          ram_wdata.len   = cur_q.len + size_q;
        end
      end
      StMerge: begin
        ram_we          = 1'b1;
        ram_waddr       = IdxW'(pos_q - CntW'(1));
        ram_wdata.start = prev_q.start;
        ram_wdata.len   = acc_q + cur_q.len;
      end
      StShiftDn: begin
        ram_we    = rv_q;
        ram_waddr = rv_idx_q - IdxW'(1);
        ram_wdata = rd_entry;
      end
      StShiftUp: begin
        ram_we    = rv_q;
        ram_waddr = rv_idx_q + IdxW'(1);
        ram_wdata = rd_entry;
      end
      StPut: begin
        ram_we          = 1'b1;
        ram_waddr       = pos_q[IdxW-1:0];
        ram_wdata.start = addr_q;
        ram_wdata.len   = size_q;
      end
      default: ;
    endcase
  end

  // result word
  always_comb begin
    res.alloc_addr  = res_addr_q;
    res.status      = res_status_q;
    res.entry_count = count_q;
    res.high_water  = peak_q;
    res.lost_frees  = lost_n_q;
    res.lost_bytes  = lost_b_q;
    res.free_total  = sum_q;
  end

  // sequencer, statistics and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cmd_q        <= CmdAlloc;
      addr_q       <= '0;
      size_q       <= '0;
      tail_q       <= '0;
      acc_q        <= '0;
      res_addr_q   <= '0;
      res_status_q <= StatusOk;
      count_q      <= '0;
      peak_q       <= '0;
      rd_idx_q     <= '0;
      pos_q        <= '0;
      lost_n_q     <= '0;
      lost_b_q     <= '0;
      sum_q        <= '0;
      rv_q         <= 1'b0;
      rv_idx_q     <= '0;
      has_prev_q   <= 1'b0;
      has_cur_q    <= 1'b0;
      more_q       <= 1'b0;
      prev_q       <= '0;
      cur_q        <= '0;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
    end else begin
      // StDone reloads the output register itself
      if (m_valid_q && m_axis_tready && (state_q != StDone)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (s_axis_tvalid) begin
            cmd_q      <= s_axis_tuser;
            addr_q     <= s_axis_tdata[31:0] & AddrMask;
            size_q     <= s_axis_tdata[63:32];
            tail_q     <= (s_axis_tdata[31:0] + s_axis_tdata[63:32]) & AddrMask;
            rd_idx_q   <= '0;
            rv_q       <= 1'b0;
            has_prev_q <= 1'b0;
            has_cur_q  <= 1'b0;
            state_q    <= StScan;
          end
        end
        StScan: begin
          rv_q     <= rd_issue && !scan_stop;
          rv_idx_q <= rd_idx_q[IdxW-1:0];
          if (rd_issue) begin
            rd_idx_q <= rd_idx_q + CntW'(1);
          end
          if (count_q == '0) begin
            pos_q   <= '0;
            state_q <= StDecide;
          end else if (rv_q) begin
            if (cmd_q == CmdAlloc) begin
              if (fits) begin
                cur_q     <= rd_entry;
                has_cur_q <= 1'b1;
                pos_q     <= CntW'(rv_idx_q);
                state_q   <= StDecide;
              end else if (last_rd) begin
                state_q <= StDecide;
              end
            end else if (rd_entry.start > addr_q) begin
              cur_q     <= rd_entry;
              has_cur_q <= 1'b1;
              pos_q     <= CntW'(rv_idx_q);
              state_q   <= StDecide;
            end else begin
              prev_q     <= rd_entry;
              has_prev_q <= 1'b1;
              if (last_rd) begin
                pos_q   <= count_q;
                state_q <= StDecide;
              end
            end
          end
        end
        StDecide: begin
          if (cmd_q == CmdAlloc) begin
            res_status_q <= has_cur_q ? StatusOk : StatusNoFit;
            if (!has_cur_q) begin
              res_addr_q <= '0;
              state_q    <= StDone;
            end else begin
              res_addr_q <= cur_q.start;
              sum_q      <= sum_q - {1'b0, size_q};
              if (cur_q.len == size_q) begin
                count_q  <= count_q - CntW'(1);
                rd_idx_q <= pos_q + CntW'(1);
                state_q  <= StShiftDn;
              end else begin
                state_q <= StDone;
              end
            end
          end else begin
            res_addr_q <= '0;
            if (prev_match) begin
              res_status_q <= StatusOk;
              sum_q        <= sum_q + {1'b0, size_q};
              if (next_match) begin
                acc_q   <= prev_q.len + size_q;
                state_q <= StMerge;
              end else begin
                state_q <= StDone;
              end
            end else if (next_match) begin
              res_status_q <= StatusOk;
              sum_q        <= sum_q + {1'b0, size_q};
              state_q      <= StDone;
            end else if (count_q < CntW'(TableDepth)) begin
              res_status_q <= StatusOk;
              count_q      <= cnt_inc;
              if (peak_q < cnt_inc) begin
                peak_q <= cnt_inc;
              end
              sum_q <= sum_q + {1'b0, size_q};
              if (pos_q < count_q) begin
                rd_idx_q <= count_q - CntW'(1);
                more_q   <= 1'b1;
                state_q  <= StShiftUp;
              end else begin
                state_q <= StPut;
              end
            end else begin
              res_status_q <= StatusLost;
              lost_n_q     <= lost_n_q + 32'd1;
              lost_b_q     <= lost_b_q + size_q;
              state_q      <= StDone;
            end
          end
        end
        StMerge: begin
          count_q  <= count_q - CntW'(1);
          rd_idx_q <= pos_q + CntW'(1);
          rv_q     <= 1'b0;
          state_q  <= StShiftDn;
        end
        StShiftDn: begin
          // move entries above the removed slot down by one
          rv_q     <= rd_issue;
          rv_idx_q <= rd_idx_q[IdxW-1:0];
          if (rd_issue) begin
            rd_idx_q <= rd_idx_q + CntW'(1);
          end else if (!rv_q) begin
            state_q <= StDone;
          end
        end
        StShiftUp: begin
          // move entries from the slot upward by one, top first
          rv_q     <= more_q;
          rv_idx_q <= rd_idx_q[IdxW-1:0];
          if (more_q) begin
            if (rd_idx_q == pos_q) begin
              more_q <= 1'b0;
            end else begin
              rd_idx_q <= rd_idx_q - CntW'(1);
            end
          end else if (!rv_q) begin
            state_q <= StPut;
          end
        end
        StPut: begin
          state_q <= StDone;
        end
        StDone: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= OutW'(res);
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready = state_q == StIdle;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

// ----- rtl/core/ffa_checker.sv -----
// Port-level checks for the first-fit free-list allocator, bound to the top.
// Depends on ffa_pkg and first_fit_free_list_allocator.
`default_nettype none

module ffa_checker import ffa_pkg::*; (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            s_axis_tvalid,
  input wire logic            s_axis_tready,
  input wire logic [InW-1:0]  s_axis_tdata,
  input wire logic            s_axis_tuser,
  input wire logic            m_axis_tvalid,
  input wire logic            m_axis_tready,
  input wire logic [OutW-1:0] m_axis_tdata
);

  result_t r;
  logic    s_take;

  assign r      = result_t'(m_axis_tdata[OutRawW-1:0]);
  assign s_take = s_axis_tvalid && s_axis_tready && (s_axis_tuser || !s_axis_tuser)
                  && (s_axis_tdata == s_axis_tdata);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // one request at a time: input closes right after a take
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_take |=> !s_axis_tready)
    else $error("input ready right after a request was taken");

  // no result can appear in the cycle after a take into an empty output
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_take && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared without any table work");

  // high-water mark covers the current count
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (r.entry_count <= r.high_water) &&
                      (r.high_water <= CntW'(TableDepth)))
    else $error("entry count above high-water mark or table size");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
